// ===== src/page_bitmap_allocator_assert.svh =====
// Assertion macros shared by the page bitmap allocator modules.
// NOW checks the consequent in the same cycle, NEXT checks it in the cycle after.
`ifndef PAGE_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page bitmap allocator check failed");
`define PBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page bitmap allocator check failed");
`else
`define PBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define PBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/pba_pkg.sv =====
package pba_pkg;

    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int PADDR_W    = 24;
    localparam int CNT_OUT_W  = 13;
    localparam int BYTES_W    = 25;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 1;

    localparam int WORD_W     = 64;
    localparam int WORD_BIT_W = 6;
    localparam int BYTE_W     = 8;
    localparam int BYTE_BIT_W = 3;
    localparam int WORD_BYTES = WORD_W / BYTE_W;

    localparam logic [BYTE_W-1:0] BYTE_FULL = 8'hFF;

    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_PAGE   = 1'b1;

    localparam logic [CFG_W-1:0] CFG_FIRST_FREE_RST = 13'd256;
    localparam logic [CFG_W-1:0] CFG_END_PAGE_RST   = 13'd4096;

    // controller -> datapath
    typedef struct packed {
        logic accept;      // item taken: reset status, load divider
        logic init_load;   // counters from config
        logic sweep_ones;  // write all-ones word, advance
        logic sweep_init;  // write init pattern word, advance
        logic scan_step;   // word full, move on
        logic scan_hit;    // capture word with a free bit
        logic scan_miss;   // no free page
        logic pick;        // choose byte
        logic mark;        // choose bit, write back
        logic div_step;    // one divide phase
        logic free_chk;    // check and clear page bit
        logic out_load;    // load result register
    } t_pba_ctl;

    // datapath -> controller
    typedef struct packed {
        logic sweep_last;
        logic word_full;
        logic div_last;
        logic out_free;
    } t_pba_sts;

endpackage

// ===== src/pba_ram.sv =====
module pba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/pba_ctrl.sv =====
`include "page_bitmap_allocator_assert.svh"

module pba_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [pba_pkg::CMD_W-1:0]    i_command,
    input  pba_pkg::t_pba_sts            i_sts,
    output pba_pkg::t_pba_ctl            o_ctl
);

    import pba_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_INIT   = 9'b000000100,
        S_SCAN   = 9'b000001000,
        S_PICK   = 9'b000010000,
        S_MARK   = 9'b000100000,
        S_DIV    = 9'b001000000,
        S_FCHK   = 9'b010000000,
        S_RESULT = 9'b100000000
    } t_state;

    t_state   r_state;
    t_state   n_state;
    t_pba_ctl ctl;

    always_comb begin
        n_state = r_state;
        ctl     = '0;
        case (r_state)
            S_CLEAR: begin
                ctl.sweep_ones = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    ctl.accept = 1'b1;
                    case (i_command)
                        CMD_INIT: begin
                            ctl.init_load = 1'b1;
                            n_state       = S_INIT;
                        end
                        CMD_ALLOC: n_state = S_SCAN;
                        CMD_FREE:  n_state = S_DIV;
                        default:   n_state = S_RESULT;
                    endcase
                end
            end
            S_INIT: begin
                ctl.sweep_init = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_RESULT;
                end
            end
            S_SCAN: begin
                if (!i_sts.word_full) begin
                    ctl.scan_hit = 1'b1;
                    n_state      = S_PICK;
                end else if (i_sts.sweep_last) begin
                    ctl.scan_miss = 1'b1;
                    n_state       = S_RESULT;
                end else begin
                    ctl.scan_step = 1'b1;
                end
            end
            S_PICK: begin
                ctl.pick = 1'b1;
                n_state  = S_MARK;
            end
            S_MARK: begin
                ctl.mark = 1'b1;
                n_state  = S_RESULT;
            end
            S_DIV: begin
                ctl.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                ctl.free_chk = 1'b1;
                n_state      = S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    ctl.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_ctl   = ctl;

    `PBA_ASSERT_NEXT(a_div_to_chk, i_clk, i_rst_n, (r_state == S_DIV) && i_sts.div_last, r_state == S_FCHK)
    `PBA_ASSERT_NEXT(a_scan_goes_on, i_clk, i_rst_n, (r_state == S_SCAN) && i_sts.word_full && !i_sts.sweep_last, r_state == S_SCAN)
    `PBA_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, (r_state == S_RESULT) && !i_sts.out_free, r_state == S_RESULT)

endmodule

// ===== src/pba_datapath.sv =====
`include "page_bitmap_allocator_assert.svh"

module pba_datapath #(
    parameter int PAGE_COUNT = 4096,
    parameter int PAGE_BYTES = 4096,
    localparam int MAP_WORDS = (PAGE_COUNT + 63) / 64,
    localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pba_pkg::t_pba_ctl                 i_ctl,
    output pba_pkg::t_pba_sts                 o_sts,
    input  logic                              i_cfg_we,
    input  logic [pba_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pba_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic [pba_pkg::ADDR_W-1:0]        i_address,
    output logic                              o_ram_we,
    output logic [WA_W-1:0]                   o_ram_waddr,
    output logic [pba_pkg::WORD_W-1:0]        o_ram_wdata,
    output logic [WA_W-1:0]                   o_ram_raddr,
    input  logic [pba_pkg::WORD_W-1:0]        i_ram_rdata,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic [pba_pkg::STATUS_W-1:0]      o_status,
    output logic [pba_pkg::PADDR_W-1:0]       o_page_address,
    output logic [pba_pkg::CNT_OUT_W-1:0]     o_free_count,
    output logic [pba_pkg::CNT_OUT_W-1:0]     o_active_count,
    output logic [pba_pkg::CNT_OUT_W-1:0]     o_wired_count,
    output logic [pba_pkg::BYTES_W-1:0]       o_free_bytes,
    output logic [pba_pkg::BYTES_W-1:0]       o_used_bytes
);

    import pba_pkg::*;

    localparam int CW     = $clog2(PAGE_COUNT + 1);
    localparam int PI_W   = WA_W + WORD_BIT_W;
    localparam int RB     = $clog2(PAGE_BYTES);
    // reciprocal for the divide by the page size, always below 2^32
    localparam logic [ADDR_W-1:0] RECIP = ADDR_W'(
        (((64'd1 << ADDR_W) * ((64'd1 << RB) - 64'(PAGE_BYTES))) / 64'(PAGE_BYTES))
        + 64'd1);

    logic [CFG_W-1:0]      r_cfg_first;
    logic [CFG_W-1:0]      r_cfg_end;
    logic [WA_W-1:0]       r_waddr;
    logic [WA_W-1:0]       n_waddr;
    logic [WORD_W-1:0]     r_word;
    logic [BYTE_BIT_W-1:0] r_byte;
    logic [PI_W-1:0]       r_pidx;
    logic [ADDR_W-1:0]     r_quo;
    logic [ADDR_W-1:0]     r_t1;
    logic                  r_dcnt;
    logic [CW-1:0]         r_free;
    logic [CW-1:0]         r_active;
    logic [CW-1:0]         r_wired;
    logic [STATUS_W-1:0]   r_status;

    logic                  r_o_valid;
    logic [STATUS_W-1:0]   r_o_status;
    logic [PADDR_W-1:0]    r_o_paddr;
    logic [CNT_OUT_W-1:0]  r_o_free;
    logic [CNT_OUT_W-1:0]  r_o_active;
    logic [CNT_OUT_W-1:0]  r_o_wired;
    logic [BYTES_W-1:0]    r_o_free_bytes;
    logic [BYTES_W-1:0]    r_o_used_bytes;

    logic [CW-1:0]         first_c;
    logic [CW-1:0]         last_c;
    logic [CW-1:0]         free_init;
    logic [CW-1:0]         used_pages;
    logic [WORD_W-1:0]     init_word;
    logic [BYTE_BIT_W-1:0] byte_sel;
    logic [BYTE_BIT_W-1:0] bit_sel;
    logic [BYTE_W-1:0]     cur_byte;
    logic [WORD_W-1:0]     mark_mask;
    logic [WORD_W-1:0]     free_mask;
    logic [2*ADDR_W-1:0]   div_prod;
    logic [ADDR_W-1:0]     div_half;
    logic [ADDR_W-1:0]     n_quo;
    logic                  div_last;
    logic                  in_range;
    logic                  page_used;
    logic                  free_ok;
    logic                  ram_we;
    logic                  out_free;
    logic                  sweep_last;

    // init clamps both bounds to the page count
    assign first_c   = (32'(r_cfg_first) > 32'(PAGE_COUNT)) ? CW'(PAGE_COUNT) : CW'(r_cfg_first);
    assign last_c    = (32'(r_cfg_end) > 32'(PAGE_COUNT)) ? CW'(PAGE_COUNT) : CW'(r_cfg_end);
    assign free_init = (last_c > first_c) ? last_c - first_c : '0;

    always_comb begin
        logic [31:0] pg;
        pg = '0;
        for (int b = 0; b < WORD_W; b++) begin
            pg           = 32'({r_waddr, WORD_BIT_W'(b)});
            init_word[b] = !((pg >= 32'(first_c)) && (pg < 32'(last_c)));
        end
    end

    // lowest byte with a free page, then lowest free bit in it
    always_comb begin
        byte_sel = '0;
        for (int i = WORD_BYTES - 1; i >= 0; i--) begin
            if (r_word[i*BYTE_W +: BYTE_W] != BYTE_FULL) begin
                byte_sel = BYTE_BIT_W'(i);
            end
        end
    end

    assign cur_byte = r_word[{r_byte, 3'b000} +: BYTE_W];

    always_comb begin
        bit_sel = '0;
        for (int j = BYTE_W - 1; j >= 0; j--) begin
            if (!cur_byte[j]) begin
                bit_sel = BYTE_BIT_W'(j);
            end
        end
    end

    assign mark_mask = WORD_W'(1) << {r_byte, bit_sel};

    // address / page size by reciprocal multiply:
    // first t1 = high half of addr * RECIP, then (t1 + ((addr - t1) >> 1)) >> (RB - 1)
    assign div_prod = (2*ADDR_W)'(r_quo) * (2*ADDR_W)'(RECIP);
    assign div_half = (r_quo - r_t1) >> 1;
    assign n_quo    = (r_t1 + div_half) >> (RB - 1);
    assign div_last = r_dcnt;

    assign in_range  = (33'(r_quo) < 33'(PAGE_COUNT));
    assign page_used = i_ram_rdata[r_quo[WORD_BIT_W-1:0]];
    assign free_ok   = in_range && page_used;
    assign free_mask = WORD_W'(1) << r_quo[WORD_BIT_W-1:0];

    assign ram_we = i_ctl.sweep_ones || i_ctl.sweep_init || i_ctl.mark
                 || (i_ctl.free_chk && free_ok);

    always_comb begin
        if (i_ctl.sweep_ones) begin
            o_ram_wdata = '1;
        end else if (i_ctl.sweep_init) begin
            o_ram_wdata = init_word;
        end else if (i_ctl.mark) begin
            o_ram_wdata = r_word | mark_mask;
        end else begin
            o_ram_wdata = i_ram_rdata & ~free_mask;
        end
    end

    // read address runs one step ahead so rdata always holds word r_waddr
    always_comb begin
        n_waddr = r_waddr;
        if (i_ctl.accept) begin
            n_waddr = '0;
        end else if (i_ctl.sweep_ones || i_ctl.sweep_init || i_ctl.scan_step) begin
            n_waddr = r_waddr + 1'b1;
        end else if (i_ctl.div_step && div_last) begin
            n_waddr = WA_W'(n_quo >> WORD_BIT_W);
        end
    end

    assign o_ram_we    = ram_we;
    assign o_ram_waddr = r_waddr;
    assign o_ram_raddr = n_waddr;

    assign sweep_last = (r_waddr == WA_W'(MAP_WORDS - 1));
    assign out_free   = !r_o_valid || !i_stall;
    assign used_pages = (r_free <= CW'(PAGE_COUNT)) ? CW'(PAGE_COUNT) - r_free : '0;

    assign o_sts.sweep_last = sweep_last;
    assign o_sts.word_full  = (i_ram_rdata == '1);
    assign o_sts.div_last   = div_last;
    assign o_sts.out_free   = out_free;

    // control state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_first <= CFG_FIRST_FREE_RST;
            r_cfg_end   <= CFG_END_PAGE_RST;
            r_waddr     <= '0;
            r_free      <= '0;
            r_active    <= '0;
            r_wired     <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_waddr <= n_waddr;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FIRST_FREE: r_cfg_first <= i_cfg_data;
                    CFG_END_PAGE:   r_cfg_end   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_ctl.init_load) begin
                r_free   <= free_init;
                r_wired  <= first_c;
                r_active <= '0;
            end else if (i_ctl.mark) begin
                if (r_free != '0) begin
                    r_free <= r_free - 1'b1;
                end
                r_active <= r_active + 1'b1;
            end else if (i_ctl.free_chk && free_ok) begin
                r_free <= r_free + 1'b1;
                if (r_active != '0) begin
                    r_active <= r_active - 1'b1;
                end
            end
            if (i_ctl.out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // working payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_status <= ST_OK;
            r_pidx   <= '0;
            r_quo    <= i_address;
            r_dcnt   <= 1'b0;
        end else begin
            if (i_ctl.div_step) begin
                if (r_dcnt) begin
                    r_quo <= n_quo;
                end else begin
                    r_t1 <= div_prod[2*ADDR_W-1:ADDR_W];
                end
                r_dcnt <= 1'b1;
            end
            if (i_ctl.scan_miss) begin
                r_status <= ST_OOM;
            end
            if (i_ctl.free_chk && !free_ok) begin
                r_status <= ST_IGN;
            end
            if (i_ctl.mark) begin
                r_pidx <= {r_waddr, r_byte, bit_sel};
            end
        end
        if (i_ctl.scan_hit) begin
            r_word <= i_ram_rdata;
        end
        if (i_ctl.pick) begin
            r_byte <= byte_sel;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_o_status     <= r_status;
            r_o_paddr      <= PADDR_W'(32'(r_pidx) * 32'(PAGE_BYTES));
            r_o_free       <= CNT_OUT_W'(r_free);
            r_o_active     <= CNT_OUT_W'(r_active);
            r_o_wired      <= CNT_OUT_W'(r_wired);
            r_o_free_bytes <= BYTES_W'(32'(r_free) * 32'(PAGE_BYTES));
            r_o_used_bytes <= BYTES_W'(32'(used_pages) * 32'(PAGE_BYTES));
        end
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_page_address = r_o_paddr;
    assign o_free_count   = r_o_free;
    assign o_active_count = r_o_active;
    assign o_wired_count  = r_o_wired;
    assign o_free_bytes   = r_o_free_bytes;
    assign o_used_bytes   = r_o_used_bytes;

    `PBA_ASSERT_NOW(a_free_bounded, i_clk, i_rst_n, 1'b1, r_free <= CW'(PAGE_COUNT))
    `PBA_ASSERT_NOW(a_mark_free_bit, i_clk, i_rst_n, i_ctl.mark, !r_word[{r_byte, bit_sel}])
    `PBA_ASSERT_NEXT(a_free_count_up, i_clk, i_rst_n, i_ctl.free_chk && ram_we, r_free == $past(r_free) + 1'b1)

endmodule

// ===== src/page_bitmap_allocator.sv =====
// First-fit page frame allocator over a used/free bitmap held in a 64-bit wide RAM,
// one bit per page (1 = used). After reset the block sweeps the map to all-used,
// with o_stall high throughout; config writes are still taken then. Commands: init
// (rewrites the whole map, one word a cycle), allocate (reads words in order through
// the single RAM read port until one has a free bit, then picks and marks it), free
// (a reciprocal multiply turns the address into a page index, then check and clear),
// and the unused code, which just reports the counts. One item is worked at a time;
// a finished result waits in the output register while the next item is taken.
// Every result carries the page counts and byte totals after the command.
module page_bitmap_allocator #(
    parameter int PAGE_COUNT = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command transfer
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [pba_pkg::CMD_W-1:0]         i_command,
    input  logic [pba_pkg::ADDR_W-1:0]        i_address,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [pba_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pba_pkg::CFG_W-1:0]         i_cfg_data,
    // result transfer
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [pba_pkg::STATUS_W-1:0]      o_status,
    output logic [pba_pkg::PADDR_W-1:0]       o_page_address,
    output logic [pba_pkg::CNT_OUT_W-1:0]     o_free_count,
    output logic [pba_pkg::CNT_OUT_W-1:0]     o_active_count,
    output logic [pba_pkg::CNT_OUT_W-1:0]     o_wired_count,
    output logic [pba_pkg::BYTES_W-1:0]       o_free_bytes,
    output logic [pba_pkg::BYTES_W-1:0]       o_used_bytes
);

    import pba_pkg::*;

    localparam int MAP_WORDS = (PAGE_COUNT + 63) / 64;
    localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    t_pba_ctl          ctl;
    t_pba_sts          sts;
    logic              ram_we;
    logic [WA_W-1:0]   ram_waddr;
    logic [WA_W-1:0]   ram_raddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    // sequencer: one state per phase of a command
    pba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_command (i_command),
        .i_sts     (sts),
        .o_ctl     (ctl)
    );

    // counters, divider, bit pick and result register
    pba_datapath #(
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_address      (i_address),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_page_address (o_page_address),
        .o_free_count   (o_free_count),
        .o_active_count (o_active_count),
        .o_wired_count  (o_wired_count),
        .o_free_bytes   (o_free_bytes),
        .o_used_bytes   (o_used_bytes)
    );

    // used/free bitmap, one 64-page word per entry
    pba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_WORDS),
        .AW    (WA_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule
